@@ rtl/core/hzc_pkg.sv @@
package hzc_pkg;

  localparam int MAX_ZONES  = 16;
  localparam int ZONE_IDX_W = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int ZONE_CNT_W = $clog2(MAX_ZONES + 1);

  localparam int SLOT_W  = 4;
  localparam int ADC_W   = 12;
  localparam int NEED_W  = 8;
  localparam int CODE_W  = 8;
  localparam int HIT_W   = 9;
  localparam int ZCNT_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [ZONE_CNT_W-1:0] ZoneMax = ZONE_CNT_W'(MAX_ZONES);
  localparam logic [HIT_W-1:0]      HitMax  = '1;

  // request kinds carried on tuser
  localparam logic [1:0] REQ_ZONE_WR = 2'd0;
  localparam logic [1:0] REQ_DETECT  = 2'd1;
  localparam logic [1:0] REQ_SAMPLE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_HIGH = 1'd1;

  typedef struct packed {
    logic              changed;
    logic [CODE_W-1:0] code;
  } hzc_result_t;

  typedef struct packed {
    logic [ADC_W-1:0]  limit;
    logic [NEED_W-1:0] need;
    logic [CODE_W-1:0] code;
  } hzc_zone_t;

endpackage

@@ rtl/core/headset_zone_classifier.sv @@
// Zone writes and detect edges need no scan; a result from a detect edge or a
// jack-absent sample is pushed at acceptance into the output (or skid) register.
// A sample in a session scans k zones (at most zone_count, capped at 16): the
// zone table and the hit-count memory have one read port each and are walked one
// entry per cycle; s_axis_tready stays low until the scan ends.
// Reset: no session, last type 0, all hit counts zero; zone table undefined.
module headset_zone_classifier import hzc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [3:0] zone_slot, [15:4] zone_adc_limit, [23:16] zone_required,
  // [31:24] zone_type_code, [32] detect_pin, [44:33] adc_sample, [47:45] zero
  input  logic [47:0]           s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,  // [1:0] req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata   // [7:0] reported_type, [8] type_changed
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_e;

  // input fields
  logic [SLOT_W-1:0] in_slot;
  logic [ADC_W-1:0]  in_limit, in_sample;
  logic [NEED_W-1:0] in_need;
  logic [CODE_W-1:0] in_code;
  logic              in_pin, present, accept;

  assign in_slot   = s_axis_tdata[3:0];
  assign in_limit  = s_axis_tdata[15:4];
  assign in_need   = s_axis_tdata[23:16];
  assign in_code   = s_axis_tdata[31:24];
  assign in_pin    = s_axis_tdata[32];
  assign in_sample = s_axis_tdata[44:33];

  // configuration
  logic [ZCNT_W-1:0] cfg_zone_count_q;
  logic              cfg_det_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_zone_count_q <= '0;
      cfg_det_high_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ZONE_COUNT:  cfg_zone_count_q <= cfg_wdata_i[ZCNT_W-1:0];
        CFG_DETECT_HIGH: cfg_det_high_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // control state
  state_e                state_q, state_d;
  logic [ZONE_IDX_W-1:0] idx_q, idx_d;
  logic [ZONE_CNT_W-1:0] n_q, n_d, n_cfg;
  logic [ADC_W-1:0]      sample_q, sample_d;
  logic                  session_q, session_d;
  logic [CODE_W-1:0]     last_type_q, last_type_d;
  logic                  buf_full;

  assign s_axis_tready = (state_q == ST_IDLE) & ~buf_full;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign present       = (in_pin == cfg_det_high_q);
  assign n_cfg = (ZONE_CNT_W'(cfg_zone_count_q) > ZoneMax) ? ZoneMax
                                                          : ZONE_CNT_W'(cfg_zone_count_q);

  // zone table memory
  hzc_zone_t             zone_mem [MAX_ZONES];
  hzc_zone_t             zone_rd_q;
  logic                  zone_we;
  logic [ZONE_IDX_W-1:0] rd_addr;

  assign zone_we = accept & (s_axis_tuser == REQ_ZONE_WR) & (int'(in_slot) < MAX_ZONES);
  assign rd_addr = (state_q == ST_IDLE) ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (zone_we) begin
      zone_mem[ZONE_IDX_W'(in_slot)] <= '{limit: in_limit, need: in_need, code: in_code};
    end
    zone_rd_q <= zone_mem[rd_addr];
  end

  // hit-count memory; a valid bit per entry stands for the cleared value
  logic [HIT_W-1:0]     hit_mem [MAX_ZONES];
  logic [HIT_W-1:0]     hit_rd_q;
  logic [MAX_ZONES-1:0] hit_vld_q;
  logic                 hit_rd_vld_q, hit_clr, hit_we;
  logic [HIT_W-1:0]     hit_cur, hit_new;

  assign hit_clr = accept & (s_axis_tuser == REQ_DETECT) & present;

  always_ff @(posedge clk_i) begin
    if (hit_we) begin
      hit_mem[idx_q] <= hit_new;
    end
    hit_rd_q <= hit_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_vld_q    <= '0;
      hit_rd_vld_q <= 1'b0;
    end else begin
      hit_rd_vld_q <= hit_vld_q[rd_addr];
      if (hit_clr) begin
        hit_vld_q <= '0;
      end else if (hit_we) begin
        hit_vld_q[idx_q] <= 1'b1;
      end
    end
  end

  // scan step
  logic zone_hit, report, last_zone;

  assign hit_cur   = hit_rd_vld_q ? hit_rd_q : '0;
  assign hit_new   = (hit_cur == HitMax) ? hit_cur : hit_cur + 1'b1;
  assign zone_hit  = (sample_q <= zone_rd_q.limit);
  assign report    = hit_new > HIT_W'(zone_rd_q.need);
  assign last_zone = (ZONE_CNT_W'(idx_q) + 1'b1) == n_q;
  assign hit_we    = (state_q == ST_SCAN) & zone_hit;

  logic              emit;
  logic [CODE_W-1:0] emit_code;
  hzc_result_t       emit_res;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    n_d       = n_q;
    sample_d  = sample_q;
    session_d = session_q;
    emit      = 1'b0;
    emit_code = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            REQ_DETECT: begin
              session_d = present;
              emit      = ~present;
            end
            REQ_SAMPLE: begin
              if (session_q) begin
                if (!present) begin
                  session_d = 1'b0;
                  emit      = 1'b1;
                end else if (n_cfg != '0) begin
                  state_d  = ST_SCAN;
                  idx_d    = '0;
                  n_d      = n_cfg;
                  sample_d = in_sample;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (zone_hit) begin
          state_d = ST_IDLE;
          if (report) begin
            session_d = 1'b0;
            emit      = 1'b1;
            emit_code = zone_rd_q.code;
          end
        end else if (last_zone) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign emit_res    = '{changed: (emit_code != last_type_q), code: emit_code};
  assign last_type_d = emit ? emit_code : last_type_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      sample_q    <= '0;
      session_q   <= 1'b0;
      last_type_q <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      sample_q    <= sample_d;
      session_q   <= session_d;
      last_type_q <= last_type_d;
    end
  end

  hzc_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (emit),
    .push_data_i   (emit_res),
    .full_o        (buf_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !buf_full)
    else $error("result pushed into a full output buffer");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ZONE_CNT_W'(idx_q) < n_q))
    else $error("scan index beyond zone count");

  a_report_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> !session_q)
    else $error("session still open after a report");

  a_scan_in_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> session_q)
    else $error("zone scan outside a session");

endmodule

@@ rtl/core/hzc_out_buf.sv @@
module hzc_out_buf import hzc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  hzc_result_t push_data_i,
  output logic        full_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [7:0] reported_type, [8] type_changed
);

  hzc_result_t out_q, out_d, skid_q, skid_d;
  logic        out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic        pop;

  assign pop = out_vld_q & m_axis_tready;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_d     = push_data_i;
        skid_vld_d = push_i;
      end else begin
        out_d     = push_data_i;
        out_vld_d = push_i;
      end
    end else if (push_i) begin
      if (!out_vld_q) begin
        out_d     = push_data_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = push_data_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o        = skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.changed, out_q.code};

endmodule

@@ dv/headset_zone_classifier_tb.sv @@
`timescale 1ns / 100ps

module headset_zone_classifier_tb;
  import hzc_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         SETTLE_CYC  = 24;
  localparam int         ITEM_TARGET = 1750;
  localparam int         CYCLE_LIMIT = 600000;

  // one input beat, lowest field last
  typedef struct packed {
    logic [ADC_W-1:0]  sample;
    logic              detect;
    logic [CODE_W-1:0] code;
    logic [NEED_W-1:0] need;
    logic [ADC_W-1:0]  limit;
    logic [SLOT_W-1:0] slot;
  } hs_req_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [3:0] zone_slot, [15:4] zone_adc_limit, [23:16] zone_required,
  // [31:24] zone_type_code, [32] detect_pin, [44:33] adc_sample, [47:45] zero
  logic [47:0]           s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;  // [1:0] req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;        // [7:0] reported_type, [8] type_changed

  headset_zone_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // classifier state as the block should hold it
  logic [ADC_W-1:0]  zone_limit [MAX_ZONES];
  logic [NEED_W-1:0] zone_need  [MAX_ZONES];
  logic [CODE_W-1:0] zone_code  [MAX_ZONES];
  logic [HIT_W-1:0]  zone_hits  [MAX_ZONES];
  logic [CODE_W-1:0] last_code   = '0;
  logic              in_session  = 1'b0;
  logic [ZCNT_W-1:0] zones_used  = '0;
  logic              detect_high = 1'b1;

  hzc_result_t expected_types[$];
  int          mismatch_count = 0;
  int          items_done     = 0;
  int          cycle_count    = 0;
  int          ready_wait     = 0;
  logic        calm           = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall per beat, compare against the oldest expectation
  always @(posedge clk_i) begin
    int gap;
    hzc_result_t want;
    if (!rst_ni) begin
      ready_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (expected_types.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual type %0d changed %0b",
                 $time, m_axis_tdata[7:0], m_axis_tdata[8]);
        mismatch_count++;
      end else begin
        want = expected_types.pop_front();
        if (m_axis_tdata[7:0] !== want.code) begin
          $display("%0t: reported_type expected %0d actual %0d",
                   $time, want.code, m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[8] !== want.changed) begin
          $display("%0t: type_changed expected %0b actual %0b",
                   $time, want.changed, m_axis_tdata[8]);
          mismatch_count++;
        end
      end
      gap = calm ? 0 : $urandom_range(0, 4);
      m_axis_tready <= (gap == 0);
      ready_wait    <= (gap == 0) ? 0 : gap - 1;
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_code(input logic [CODE_W-1:0] c);
    expected_types.push_back(hzc_result_t'({c != last_code, c}));
    last_code = c;
  endtask

  task automatic classify_item(input logic [1:0] kind, input hs_req_t b);
    logic present;
    logic matched;
    int   n;
    present = (b.detect == detect_high);
    matched = 1'b0;
    case (kind)
      REQ_ZONE_WR: begin
        zone_limit[b.slot] = b.limit;
        zone_need[b.slot]  = b.need;
        zone_code[b.slot]  = b.code;
      end
      REQ_DETECT: begin
        if (!present) begin
          in_session = 1'b0;
          report_code('0);
        end else begin
          foreach (zone_hits[i]) zone_hits[i] = '0;
          in_session = 1'b1;
        end
      end
      REQ_SAMPLE: begin
        if (in_session && !present) begin
          in_session = 1'b0;
          report_code('0);
        end else if (in_session) begin
          n = (zones_used > MAX_ZONES) ? MAX_ZONES : int'(zones_used);
          for (int i = 0; i < n && !matched; i++) begin
            if (b.sample <= zone_limit[i]) begin
              matched = 1'b1;
              if (zone_hits[i] != HitMax) zone_hits[i] = zone_hits[i] + 1'b1;
              if (zone_hits[i] > zone_need[i]) begin
                in_session = 1'b0;
                report_code(zone_code[i]);
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // one beat: random gap, hold until accepted, then update the expected types
  task automatic send_item(input logic [1:0] kind, input hs_req_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, b};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!(kind == REQ_UNUSED || (kind == REQ_SAMPLE && !in_session))) items_done++;
    classify_item(kind, b);
  endtask

  function automatic hs_req_t noise_body();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(hs_req_t)-1:0];
  endfunction

  task automatic send_zone(input int slot, input int limit, input int need, input int code);
    hs_req_t b;
    b = noise_body();
    b.slot  = SLOT_W'(slot);
    b.limit = ADC_W'(limit);
    b.need  = NEED_W'(need);
    b.code  = CODE_W'(code);
    send_item(REQ_ZONE_WR, b);
  endtask

  task automatic send_detect(input logic pin);
    hs_req_t b;
    b = noise_body();
    b.detect = pin;
    send_item(REQ_DETECT, b);
  endtask

  task automatic send_sample(input logic pin, input logic [ADC_W-1:0] value);
    hs_req_t b;
    b = noise_body();
    b.detect = pin;
    b.sample = value;
    send_item(REQ_SAMPLE, b);
  endtask

  // block idle: all results in, plus slack for a scan that produces nothing
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_types.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ZONE_COUNT) zones_used = ZCNT_W'(value);
    else detect_high = value[0];
    @(posedge clk_i);
  endtask

  function automatic logic [ADC_W-1:0] pick_sample();
    int               n;
    logic [ADC_W-1:0] lim;
    n = (zones_used > MAX_ZONES) ? MAX_ZONES : int'(zones_used);
    if (n == 0 || $urandom_range(0, 3) == 0) return ADC_W'($urandom);
    lim = zone_limit[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 2))
      0:       return lim;
      1:       return (lim == '1) ? lim : lim + 1'b1;
      default: return ADC_W'($urandom_range(0, int'(lim)));
    endcase
  endfunction

  // zone_count is 0 after reset, so no sample scans the zone table here
  task automatic test_idle_behaviour();
    send_sample(1'b1, '1);
    send_item(REQ_UNUSED, noise_body());
    send_detect(1'b0);
    send_detect(1'b1);
    send_sample(1'b1, '0);
    send_sample(1'b0, 12'd100);
    drain_and_settle();
  endtask

  // every slot loaded before any search can reach it
  task automatic test_zone_table();
    for (int i = 0; i < MAX_ZONES; i++) begin
      send_zone(i, (i == MAX_ZONES - 1) ? 4095 : i * 273,
                (i == MAX_ZONES - 1) ? 255 : i % 3, 255 - 17 * i);
    end
    drain_and_settle();
    write_reg(CFG_ZONE_COUNT, MAX_ZONES);
  endtask

  task automatic test_classification();
    send_detect(1'b1);
    send_sample(1'b1, '0);        // zone 0 needs no repeat
    send_detect(1'b1);
    send_sample(1'b1, '0);        // same type again, not changed
    send_detect(1'b1);
    send_sample(1'b1, 12'd546);   // on the limit of zone 2
    send_sample(1'b1, 12'd547);   // just above: zone 3
    drain_and_settle();
    write_reg(CFG_ZONE_COUNT, 31);
    send_detect(1'b1);
    send_sample(1'b1, '1);        // top zone, far from its need
    send_sample(1'b0, '1);        // jack pulled mid-session
    drain_and_settle();
  endtask

  task automatic test_detect_polarity();
    write_reg(CFG_DETECT_HIGH, 0);
    send_detect(1'b1);
    send_detect(1'b0);
    send_sample(1'b0, 12'd1);
    send_sample(1'b0, 12'd273);
    drain_and_settle();
  endtask

  task automatic run_session();
    int steps;
    int roll;
    send_detect(detect_high);
    steps = 0;
    while (in_session && steps < 48) begin
      roll = $urandom_range(0, 99);
      if (roll < 88) send_sample(detect_high, pick_sample());
      else if (roll < 92) send_sample(!detect_high, ADC_W'($urandom));
      else if (roll < 95) send_detect(detect_high);
      else if (roll < 97) send_detect(!detect_high);
      else send_zone($urandom_range(0, 15), $urandom_range(0, 4095),
                     $urandom_range(0, 255), $urandom_range(0, 255));
      steps++;
    end
  endtask

  task automatic test_random_sessions();
    int zc;
    while (items_done < ITEM_TARGET) begin
      drain_and_settle();
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       zc = 0;
        1:       zc = MAX_ZONES;
        2:       zc = $urandom_range(MAX_ZONES + 1, 31);
        default: zc = $urandom_range(1, MAX_ZONES);
      endcase
      write_reg(CFG_ZONE_COUNT, zc);
      write_reg(CFG_DETECT_HIGH, $urandom_range(0, 1));
      repeat ($urandom_range(0, 6)) begin
        send_zone($urandom_range(0, 15), $urandom_range(0, 4095),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4),
                  $urandom_range(0, 255));
      end
      repeat ($urandom_range(2, 6)) begin
        run_session();
        if (!in_session && $urandom_range(0, 3) == 0) begin
          send_sample(1'($urandom_range(0, 1)), ADC_W'($urandom));
        end
        if ($urandom_range(0, 7) == 0) send_item(REQ_UNUSED, noise_body());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_behaviour();
    test_zone_table();
    test_classification();
    test_detect_polarity();
    test_random_sessions();
    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
